@@ design/vrap_pkg.sv @@
// Package for the video RAM access port: field widths, transaction kind and
// port mode codes, and the command/status structs between controller and datapath.
// No dependencies.
package vrap_pkg;

    localparam int KIND_W = 2;
    localparam int OFF_W  = 5;
    localparam int BYTE_W = 8;
    localparam int ADDR_W = 16;

    localparam logic [KIND_W-1:0] K_ADDR_WR = 2'd0;
    localparam logic [KIND_W-1:0] K_DATA_RD = 2'd1;
    localparam logic [KIND_W-1:0] K_DATA_WR = 2'd2;

    localparam logic [2:0] M_PAIR_LATCH0 = 3'd1;
    localparam logic [2:0] M_PAIR_LATCH1 = 3'd2;
    localparam logic [2:0] M_ALTERNATE   = 3'd3;
    localparam logic [2:0] M_ODD_BYTE    = 3'd5;
    localparam logic [2:0] M_EVEN_BYTE   = 3'd6;

    localparam logic [ADDR_W-1:0] ADDR_HI_MASK = 16'hfe00;
    localparam logic [ADDR_W-1:0] ADDR_LO_MASK = 16'h01fe;
    localparam logic [BYTE_W-1:0] NIB_HI_MASK  = 8'hf0;
    localparam logic [BYTE_W-1:0] NIB_LO_MASK  = 8'h0f;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              port_select;
        logic [OFF_W-1:0]  port_offset;
        logic [BYTE_W-1:0] write_data;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] read_data;
        logic [ADDR_W-1:0] address_after;
        logic              unknown_mode;
    } t_out_item;

    typedef struct packed {
        logic clr_wr;
        logic capture;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic out_free;
    } t_stat;

endpackage

@@ design/vrap_if.sv @@
// Valid/ready channel interfaces for the video RAM access port.
// Depends on vrap_pkg for field widths.
interface vrap_in_if import vrap_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic              port_select;
    logic [OFF_W-1:0]  port_offset;
    logic [BYTE_W-1:0] write_data;

    modport source (output valid, kind, port_select, port_offset, write_data, input ready);
    modport sink   (input valid, kind, port_select, port_offset, write_data, output ready);
endinterface

interface vrap_out_if import vrap_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] read_data;
    logic [ADDR_W-1:0] address_after;
    logic              unknown_mode;

    modport source (output valid, read_data, address_after, unknown_mode, input ready);
    modport sink   (input valid, read_data, address_after, unknown_mode, output ready);
endinterface

@@ design/video_ram_access_port_core.sv @@
// Top level of the video RAM access port: controller plus datapath.
// Uses vrap_pkg, vrap_if, vrap_ctrl and vrap_datapath.
//
// Each transaction is accepted in the idle state, which reads the addressed
// 16-bit RAM row into a register; the execute state writes it back (byte
// lanes, with the nibble merge when transparency is on) and loads the output
// register. A result may wait in that register while the next transaction is
// accepted; the commit stalls only if the previous result is still untaken.
// After reset the RAM is cleared one row per cycle, all VRAM_BYTES/2 rows
// (32768 at the default), during which input ready stays low; configuration
// writes are taken at any time.
module video_ram_access_port_core import vrap_pkg::*; #(
    parameter int VRAM_BYTES = 65536
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    vrap_in_if.sink    i_in,
    vrap_out_if.source o_out
);

    t_cmd     cmd;
    t_stat    stat;
    t_in_item item;

    assign item = '{kind: i_in.kind, port_select: i_in.port_select,
                    port_offset: i_in.port_offset, write_data: i_in.write_data};

    vrap_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    vrap_datapath #(
        .VRAM_BYTES (VRAM_BYTES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (item),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out       (o_out)
    );

endmodule

@@ design/vrap_ctrl.sv @@
// Controller state machine for the video RAM access port.
// Sequences the post-reset RAM clear, transaction capture and commit; uses vrap_pkg.
module vrap_ctrl import vrap_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ design/vrap_datapath.sv @@
// Datapath for the video RAM access port: address registers, byte latches,
// offset decode, nibble merge, the RAM and the output register. Uses vrap_pkg, vrap_if.
module vrap_datapath import vrap_pkg::*; #(
    parameter int VRAM_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  t_in_item    i_item,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    vrap_out_if.source  o_out
);

    localparam int ROWS  = VRAM_BYTES / 2;
    localparam int ROW_W = $clog2(ROWS);

    function automatic logic [BYTE_W-1:0] merge_clear(input logic [BYTE_W-1:0] d,
                                                      input logic [BYTE_W-1:0] old);
        logic [BYTE_W-1:0] m;
        m = d;
        if ((d & NIB_HI_MASK) == '0) m = m | (old & NIB_HI_MASK);
        if ((d & NIB_LO_MASK) == '0) m = m | (old & NIB_LO_MASK);
        return m;
    endfunction

    logic [2*BYTE_W-1:0] mem [ROWS];

    logic                r_layout;
    logic [ADDR_W-1:0]   r_addr  [2];
    logic [BYTE_W-1:0]   r_latch [4];
    t_in_item            r_item;
    logic [2*BYTE_W-1:0] r_row;
    logic [ROW_W-1:0]    r_clr_cnt;
    logic                r_out_valid;
    t_out_item           r_out;

    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] a_step;
    logic [ADDR_W-1:0] a_alt;
    logic [ADDR_W-1:0] a_new;
    logic [OFF_W-1:0]  o;
    logic [2:0]        mode;
    logic              inc;
    logic              trans;
    logic [BYTE_W-1:0] d;
    logic [BYTE_W-1:0] old;
    logic [BYTE_W-1:0] rd;
    logic              unk;
    logic [1:0]        we;
    logic [BYTE_W-1:0] w_lo;
    logic [BYTE_W-1:0] w_hi;
    logic              lat0_we;
    logic              lat1_we;
    logic [BYTE_W-1:0] lat0_val;
    logic [BYTE_W-1:0] lat1_val;

    always_comb begin
        d        = r_item.write_data;
        a        = r_addr[r_item.port_select];
        o        = r_layout ? {r_item.port_offset[4], r_item.port_offset[0],
                               r_item.port_offset[3:1]} : r_item.port_offset;
        mode     = o[2:0];
        inc      = o[3];
        trans    = o[4] & r_item.port_select;
        a_step   = a + {{(ADDR_W-2){1'b0}}, inc, 1'b0};
        a_alt    = (a + {{(ADDR_W-2){1'b0}}, inc & a[0], 1'b0}) ^ {{(ADDR_W-1){1'b0}}, 1'b1};
        old      = a[0] ? r_row[2*BYTE_W-1:BYTE_W] : r_row[BYTE_W-1:0];
        a_new    = a;
        rd       = '0;
        unk      = 1'b0;
        we       = 2'b00;
        w_lo     = d;
        w_hi     = d;
        lat0_we  = 1'b0;
        lat1_we  = 1'b0;
        lat0_val = r_latch[{r_item.port_select, 1'b0}];
        lat1_val = r_latch[{r_item.port_select, 1'b1}];
        case (r_item.kind)
            K_ADDR_WR: begin
                if (r_item.port_offset == '0) begin
                    a_new = (a & ADDR_HI_MASK) | ({7'h00, d, 1'b0} & ADDR_LO_MASK);
                end else begin
                    a_new = ({d[6:0], 9'h000} & ADDR_HI_MASK) | (a & ADDR_LO_MASK);
                end
            end
            K_DATA_RD: begin
                case (mode)
                    M_ALTERNATE: begin
                        rd    = old;
                        a_new = a_alt;
                    end
                    M_ODD_BYTE: begin
                        rd    = r_row[2*BYTE_W-1:BYTE_W];
                        a_new = a_step;
                    end
                    M_EVEN_BYTE: begin
                        rd    = r_row[BYTE_W-1:0];
                        a_new = a_step;
                    end
                    default: unk = 1'b1;
                endcase
            end
            K_DATA_WR: begin
                case (mode)
                    M_PAIR_LATCH0: begin
                        we    = 2'b11;
                        w_lo  = lat0_val;
                        a_new = a_step;
                    end
                    M_PAIR_LATCH1: begin
                        we    = 2'b11;
                        w_hi  = lat1_val;
                        a_new = a_step;
                    end
                    M_ALTERNATE: begin
                        we    = a[0] ? 2'b10 : 2'b01;
                        w_lo  = trans ? merge_clear(d, old) : d;
                        w_hi  = w_lo;
                        a_new = a_alt;
                    end
                    M_ODD_BYTE: begin
                        we      = 2'b10;
                        lat1_we = 1'b1;
                        w_hi    = trans ? merge_clear(d, r_row[2*BYTE_W-1:BYTE_W]) : d;
                        a_new   = a_step;
                    end
                    M_EVEN_BYTE: begin
                        we      = 2'b01;
                        lat0_we = 1'b1;
                        w_lo    = trans ? merge_clear(d, r_row[BYTE_W-1:0]) : d;
                        a_new   = a_step;
                    end
                    default: unk = 1'b1;
                endcase
            end
            default: unk = 1'b1;
        endcase
    end

    // RAM: clear sweep, commit writes with byte lanes, row read at capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            mem[r_clr_cnt] <= '0;
        end else if (i_cmd.commit) begin
            if (we[0]) mem[a[ROW_W:1]][BYTE_W-1:0]        <= w_lo;
            if (we[1]) mem[a[ROW_W:1]][2*BYTE_W-1:BYTE_W] <= w_hi;
        end
        if (i_cmd.capture) begin
            r_row <= mem[r_addr[i_item.port_select][ROW_W:1]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_item;
        end
        if (i_cmd.commit) begin
            r_out <= '{read_data: rd, address_after: a_new, unknown_mode: unk};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layout    <= 1'b0;
            r_addr      <= '{default: '0};
            r_latch     <= '{default: '0};
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_layout <= i_cfg_wdata;
            end
            if (i_cmd.clr_wr) begin
                r_clr_cnt <= r_clr_cnt + ROW_W'(1);
            end
            if (i_cmd.commit) begin
                r_addr[r_item.port_select] <= a_new;
                if (lat0_we) r_latch[{r_item.port_select, 1'b0}] <= d;
                if (lat1_we) r_latch[{r_item.port_select, 1'b1}] <= d;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.clr_last = (r_clr_cnt == ROW_W'(ROWS - 1));
    assign o_stat.out_free = !r_out_valid || o_out.ready;

    assign o_out.valid         = r_out_valid;
    assign o_out.read_data     = r_out.read_data;
    assign o_out.address_after = r_out.address_after;
    assign o_out.unknown_mode  = r_out.unknown_mode;

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// Testbench for video_ram_access_port_core: directed and random port transactions,
// each checked against an in-bench model of the VRAM, address registers and latches.
// Depends on vrap_pkg, vrap_if and the core RTL.
module tb_top;
    import vrap_pkg::*;

    localparam logic [KIND_W-1:0] K_RESERVED  = 2'd3;
    localparam logic [2:0]        M_NONE_0    = 3'd0;
    localparam logic [2:0]        M_NONE_4    = 3'd4;
    localparam logic [2:0]        M_NONE_7    = 3'd7;
    localparam logic [OFF_W-1:0]  OFF_ADDR_LO = 5'd0;
    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 11;
    localparam int TIMEOUT_NS    = 6_000_000;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 4;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    vrap_in_if  in_if ();
    vrap_out_if out_if ();

    video_ram_access_port_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    bit [BYTE_W-1:0] vram_model [0:65535];
    bit [ADDR_W-1:0] port_addr_model [0:1];
    bit [BYTE_W-1:0] latch_model [0:3];
    bit              layout_sel;

    t_out_item   access_results_q [$];
    int unsigned error_count;
    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;

    function automatic logic [ADDR_W-1:0] alt_next(input logic [ADDR_W-1:0] a, input logic step);
        if (step && a[0]) begin
            a = a + 16'd2;
        end
        return a ^ 16'h0001;
    endfunction

    // zero nibble of new data keeps the old nibble
    function automatic logic [BYTE_W-1:0] merge_nibbles(input logic [BYTE_W-1:0] d,
                                                       input logic [BYTE_W-1:0] old);
        if ((d & NIB_HI_MASK) == '0) d = d | (old & NIB_HI_MASK);
        if ((d & NIB_LO_MASK) == '0) d = d | (old & NIB_LO_MASK);
        return d;
    endfunction

    function automatic t_out_item predict_access(input t_in_item t);
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] a_odd;
        logic [ADDR_W-1:0] a_even;
        logic [ADDR_W-1:0] inc;
        logic [OFF_W-1:0]  o;
        logic [BYTE_W-1:0] d;
        logic [BYTE_W-1:0] rd;
        logic              unk;
        logic              see_through;
        int                p;
        t_out_item         r;
        p = int'(t.port_select);
        a = port_addr_model[p];
        d = t.write_data;
        rd = '0;
        unk = 1'b0;
        case (t.kind)
            K_ADDR_WR: begin
                if (t.port_offset == OFF_ADDR_LO) a = {a[15:9], d, 1'b0};
                else a = {d[6:0], a[8:1], 1'b0};
            end
            K_DATA_RD, K_DATA_WR: begin
                o = t.port_offset;
                if (layout_sel) o = {o[4], o[0], o[3:1]};
                inc = o[3] ? 16'd2 : 16'd0;
                see_through = o[4] & t.port_select;
                a_odd = {a[15:1], 1'b1};
                a_even = {a[15:1], 1'b0};
                if (t.kind == K_DATA_RD) begin
                    case (o[2:0])
                        M_ALTERNATE: begin
                            rd = vram_model[a];
                            a = alt_next(a, o[3]);
                        end
                        M_ODD_BYTE: begin
                            rd = vram_model[a_odd];
                            a = a + inc;
                        end
                        M_EVEN_BYTE: begin
                            rd = vram_model[a_even];
                            a = a + inc;
                        end
                        default: unk = 1'b1;
                    endcase
                end else begin
                    case (o[2:0])
                        M_PAIR_LATCH0: begin
                            vram_model[a_even] = latch_model[2*p];
                            vram_model[a_odd] = d;
                            a = a + inc;
                        end
                        M_PAIR_LATCH1: begin
                            vram_model[a_even] = d;
                            vram_model[a_odd] = latch_model[2*p+1];
                            a = a + inc;
                        end
                        M_ALTERNATE: begin
                            if (see_through) d = merge_nibbles(d, vram_model[a]);
                            vram_model[a] = d;
                            a = alt_next(a, o[3]);
                        end
                        M_ODD_BYTE: begin
                            latch_model[2*p+1] = d;
                            if (see_through) d = merge_nibbles(d, vram_model[a_odd]);
                            vram_model[a_odd] = d;
                            a = a + inc;
                        end
                        M_EVEN_BYTE: begin
                            latch_model[2*p] = d;
                            if (see_through) d = merge_nibbles(d, vram_model[a_even]);
                            vram_model[a_even] = d;
                            a = a + inc;
                        end
                        default: unk = 1'b1;
                    endcase
                end
            end
            default: unk = 1'b1;
        endcase
        port_addr_model[p] = a;
        r.read_data = rd;
        r.address_after = a;
        r.unknown_mode = unk;
        return r;
    endfunction

    function automatic logic [OFF_W-1:0] enc_off(input logic [2:0] mode, input logic step,
                                                 input logic trans);
        return layout_sel ? {trans, mode, step} : {trans, step, mode};
    endfunction

    function automatic logic [2:0] pick_mode(input bit is_wr);
        if ($urandom_range(99) < 8) begin
            case ($urandom_range(4))
                0: return M_NONE_0;
                1: return M_NONE_4;
                2: return M_NONE_7;
                3: return M_PAIR_LATCH0;
                default: return M_PAIR_LATCH1;
            endcase
        end
        if (is_wr) begin
            case ($urandom_range(4))
                0: return M_PAIR_LATCH0;
                1: return M_PAIR_LATCH1;
                2: return M_ALTERNATE;
                3: return M_ODD_BYTE;
                default: return M_EVEN_BYTE;
            endcase
        end
        case ($urandom_range(2))
            0: return M_ALTERNATE;
            1: return M_ODD_BYTE;
            default: return M_EVEN_BYTE;
        endcase
    endfunction

    // biased toward zero nibbles so the transparency merge gets hit
    function automatic logic [BYTE_W-1:0] rand_byte();
        logic [BYTE_W-1:0] b;
        b = 8'($urandom);
        case ($urandom_range(5))
            0: b[7:4] = 4'h0;
            1: b[3:0] = 4'h0;
            2: b = 8'h00;
            default: ;
        endcase
        return b;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            error_count++;
            $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_out_item got;
        t_out_item want;
        t_in_item  txn;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                got.read_data = out_if.read_data;
                got.address_after = out_if.address_after;
                got.unknown_mode = out_if.unknown_mode;
                if (access_results_q.size() == 0) begin
                    error_count++;
                    $display("%0t: result with no transaction pending, actual 0x%0h",
                             $time, got);
                end else begin
                    want = access_results_q.pop_front();
                    check_field("read_data", 32'(want.read_data), 32'(got.read_data));
                    check_field("address_after", 32'(want.address_after),
                                32'(got.address_after));
                    check_field("unknown_mode", 32'(want.unknown_mode),
                                32'(got.unknown_mode));
                end
            end
            if (in_if.valid && in_if.ready) begin
                txn.kind = in_if.kind;
                txn.port_select = in_if.port_select;
                txn.port_offset = in_if.port_offset;
                txn.write_data = in_if.write_data;
                access_results_q.push_back(predict_access(txn));
            end
        end
    end

    always @(posedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    task automatic send_txn(input logic [KIND_W-1:0] kind, input logic p,
                            input logic [OFF_W-1:0] off, input logic [BYTE_W-1:0] d);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.kind <= kind;
        in_if.port_select <= p;
        in_if.port_offset <= off;
        in_if.write_data <= d;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
    endtask

    task automatic wait_idle();
        int unsigned guard;
        guard = 0;
        in_if.valid <= 1'b0;
        do begin
            @(posedge i_clk);
            guard++;
        end while (access_results_q.size() != 0 && guard < DRAIN_LIMIT);
        if (access_results_q.size() != 0) begin
            error_count++;
            $display("%0t: %0d expected results never arrived", $time, access_results_q.size());
            access_results_q.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_layout(input bit v);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        layout_sel = v;
    endtask

    task automatic set_idle(input int unsigned tx_pct, input int unsigned rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
    endtask

    task automatic test_address_writes();
        send_txn(K_ADDR_WR, 1'b0, OFF_ADDR_LO, 8'hFF);
        send_txn(K_ADDR_WR, 1'b0, 5'd31, 8'hFF);
        send_txn(K_ADDR_WR, 1'b1, 5'd1, 8'h00);
        send_txn(K_ADDR_WR, 1'b1, OFF_ADDR_LO, 8'h80);
    endtask

    task automatic test_data_modes();
        // port 0 sits at 0xfffe: first step wraps to 0
        send_txn(K_DATA_WR, 1'b0, enc_off(M_EVEN_BYTE, 1'b1, 1'b0), 8'hA5);
        send_txn(K_DATA_WR, 1'b0, enc_off(M_ODD_BYTE, 1'b0, 1'b0), 8'h3C);
        send_txn(K_DATA_WR, 1'b0, enc_off(M_PAIR_LATCH0, 1'b1, 1'b0), 8'h5A);
        send_txn(K_DATA_WR, 1'b0, enc_off(M_PAIR_LATCH1, 1'b0, 1'b0), 8'hC3);
        send_txn(K_DATA_WR, 1'b0, enc_off(M_ALTERNATE, 1'b1, 1'b0), 8'h81);
        send_txn(K_DATA_WR, 1'b0, enc_off(M_ALTERNATE, 1'b1, 1'b0), 8'h7E);
        send_txn(K_ADDR_WR, 1'b0, OFF_ADDR_LO, 8'h00);
        send_txn(K_DATA_RD, 1'b0, enc_off(M_ALTERNATE, 1'b1, 1'b0), 8'h00);
        send_txn(K_DATA_RD, 1'b0, enc_off(M_ALTERNATE, 1'b1, 1'b0), 8'hFF);
        send_txn(K_DATA_RD, 1'b0, enc_off(M_ODD_BYTE, 1'b0, 1'b0), 8'h00);
        send_txn(K_DATA_RD, 1'b0, enc_off(M_EVEN_BYTE, 1'b1, 1'b0), 8'h00);
    endtask

    task automatic test_transparency();
        send_txn(K_DATA_WR, 1'b1, enc_off(M_EVEN_BYTE, 1'b0, 1'b0), 8'h96);
        send_txn(K_DATA_WR, 1'b1, enc_off(M_EVEN_BYTE, 1'b0, 1'b1), 8'h0F);
        send_txn(K_DATA_WR, 1'b1, enc_off(M_ODD_BYTE, 1'b0, 1'b1), 8'hF0);
        send_txn(K_DATA_WR, 1'b1, enc_off(M_ALTERNATE, 1'b1, 1'b1), 8'h00);
        send_txn(K_DATA_WR, 1'b1, enc_off(M_PAIR_LATCH0, 1'b0, 1'b1), 8'h00);
        // port 0 never merges
        send_txn(K_DATA_WR, 1'b0, enc_off(M_EVEN_BYTE, 1'b0, 1'b1), 8'h00);
        send_txn(K_DATA_RD, 1'b1, enc_off(M_EVEN_BYTE, 1'b0, 1'b0), 8'h00);
    endtask

    task automatic test_unknown_modes();
        send_txn(K_DATA_RD, 1'b0, enc_off(M_NONE_0, 1'b0, 1'b0), 8'h00);
        send_txn(K_DATA_RD, 1'b1, enc_off(M_PAIR_LATCH1, 1'b1, 1'b1), 8'hFF);
        send_txn(K_DATA_RD, 1'b0, enc_off(M_NONE_7, 1'b1, 1'b0), 8'h55);
        send_txn(K_DATA_WR, 1'b1, enc_off(M_NONE_4, 1'b0, 1'b1), 8'hAA);
        send_txn(K_DATA_WR, 1'b0, enc_off(M_NONE_7, 1'b1, 1'b0), 8'hFF);
        send_txn(K_RESERVED, 1'b1, 5'd31, 8'hFF);
    endtask

    task automatic test_alternate_layout();
        set_layout(1'b1);
        send_txn(K_DATA_WR, 1'b1, enc_off(M_ODD_BYTE, 1'b1, 1'b1), 8'h0C);
        send_txn(K_DATA_RD, 1'b1, enc_off(M_EVEN_BYTE, 1'b1, 1'b0), 8'h00);
        send_txn(K_DATA_RD, 1'b0, 5'h0F, 8'h00);
        send_txn(K_ADDR_WR, 1'b0, 5'h08, 8'h01);
    endtask

    // address setup followed by a burst of accesses, with some noise mixed in
    task automatic test_random(input int unsigned n_items);
        int unsigned sent;
        int unsigned burst_len;
        logic        p;
        bit          is_wr;
        logic [2:0]  mode;
        sent = 0;
        while (sent < n_items) begin
            p = 1'($urandom_range(1));
            if ($urandom_range(99) < 12) begin
                send_txn(2'($urandom_range(3)), p, 5'($urandom_range(31)),
                         8'($urandom_range(255)));
                sent++;
            end else begin
                if ($urandom_range(3) != 0) begin
                    send_txn(K_ADDR_WR, p, OFF_ADDR_LO, 8'($urandom_range(255)));
                    send_txn(K_ADDR_WR, p, 5'($urandom_range(31, 1)),
                             ($urandom_range(7) == 0) ? 8'($urandom_range(255))
                                                      : 8'($urandom_range(1)));
                    sent += 2;
                end
                burst_len = $urandom_range(10, 1);
                repeat (burst_len) begin
                    is_wr = ($urandom_range(99) < 55);
                    mode = pick_mode(is_wr);
                    send_txn(is_wr ? K_DATA_WR : K_DATA_RD, p,
                             enc_off(mode, 1'($urandom_range(1)), 1'($urandom_range(1))),
                             rand_byte());
                    sent++;
                end
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = 1'b0;
        in_if.valid = 1'b0;
        in_if.kind = K_ADDR_WR;
        in_if.port_select = 1'b0;
        in_if.port_offset = '0;
        in_if.write_data = '0;
        layout_sel = 1'b0;
        error_count = 0;
        set_idle(36, 81);
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_address_writes();
        test_data_modes();
        test_transparency();
        test_unknown_modes();
        test_alternate_layout();

        test_random(550);
        set_layout(1'b0);
        set_idle(81, 36);
        test_random(550);
        set_layout(1'b1);
        set_idle(0, 0);
        test_random(275);
        set_layout(1'b0);
        test_random(275);
        wait_idle();

        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #TIMEOUT_NS;
        $display("TB_ERROR");
        $finish;
    end

endmodule
